FILE: src/trc_pkg.sv
// Shared types, constants, rotor tables and mod-26 helpers for the rotor cipher.
package trc_pkg;

  localparam logic [5:0] ALPHA_LEN   = 6'd26;
  localparam logic [4:0] MIDDLE_TURN = 5'd17;
  localparam logic [4:0] LEFT_TURN   = 5'd5;

  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_Z   = 8'h5a;
  localparam logic [7:0] CHAR_LO_A   = 8'h61;
  localparam logic [7:0] CHAR_LO_Z   = 8'h7a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [1:0] CFG_START_RIGHT  = 2'd0;
  localparam logic [1:0] CFG_START_MIDDLE = 2'd1;
  localparam logic [1:0] CFG_START_LEFT   = 2'd2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // forward wirings, inverse wirings and reflector, letter index in and out
  localparam logic [4:0] WIRE_R [26] = '{
    5'd4, 5'd10, 5'd12, 5'd5, 5'd11, 5'd6, 5'd3, 5'd16, 5'd21, 5'd25, 5'd13, 5'd19, 5'd14,
    5'd22, 5'd24, 5'd7, 5'd23, 5'd20, 5'd18, 5'd15, 5'd0, 5'd8, 5'd1, 5'd17, 5'd2, 5'd9};
  localparam logic [4:0] WIRE_M [26] = '{
    5'd0, 5'd9, 5'd3, 5'd10, 5'd18, 5'd8, 5'd17, 5'd20, 5'd23, 5'd1, 5'd11, 5'd7, 5'd22,
    5'd19, 5'd12, 5'd2, 5'd16, 5'd6, 5'd25, 5'd13, 5'd15, 5'd24, 5'd5, 5'd21, 5'd14, 5'd4};
  localparam logic [4:0] WIRE_L [26] = '{
    5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd2, 5'd15, 5'd17, 5'd19, 5'd23, 5'd21, 5'd25,
    5'd13, 5'd24, 5'd4, 5'd8, 5'd22, 5'd6, 5'd0, 5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14};
  localparam logic [4:0] INV_R [26] = '{
    5'd20, 5'd22, 5'd24, 5'd6, 5'd0, 5'd3, 5'd5, 5'd15, 5'd21, 5'd25, 5'd1, 5'd4, 5'd2,
    5'd10, 5'd12, 5'd19, 5'd7, 5'd23, 5'd18, 5'd11, 5'd17, 5'd8, 5'd13, 5'd16, 5'd14, 5'd9};
  localparam logic [4:0] INV_M [26] = '{
    5'd0, 5'd9, 5'd15, 5'd2, 5'd25, 5'd22, 5'd17, 5'd11, 5'd5, 5'd1, 5'd3, 5'd10, 5'd14,
    5'd19, 5'd24, 5'd20, 5'd16, 5'd6, 5'd4, 5'd13, 5'd7, 5'd23, 5'd12, 5'd8, 5'd21, 5'd18};
  localparam logic [4:0] INV_L [26] = '{
    5'd19, 5'd0, 5'd6, 5'd1, 5'd15, 5'd2, 5'd18, 5'd3, 5'd16, 5'd4, 5'd20, 5'd5, 5'd21,
    5'd13, 5'd25, 5'd7, 5'd24, 5'd8, 5'd23, 5'd9, 5'd22, 5'd11, 5'd17, 5'd10, 5'd14, 5'd12};
  localparam logic [4:0] REFL [26] = '{
    5'd24, 5'd17, 5'd20, 5'd7, 5'd16, 5'd18, 5'd11, 5'd3, 5'd15, 5'd23, 5'd13, 5'd6, 5'd14,
    5'd10, 5'd12, 5'd8, 5'd4, 5'd1, 5'd5, 5'd25, 5'd2, 5'd22, 5'd21, 5'd9, 5'd0, 5'd19};

  // one request in flight: letter index or raw byte, plus rotor positions (all < 26)
  typedef struct packed {
    logic       is_letter;
    logic [7:0] data;
    logic [4:0] pos_r;
    logic [4:0] pos_m;
    logic [4:0] pos_l;
  } trc_item_t;

  // value below 32 reduced mod 26
  function automatic logic [4:0] mod26_reduce(input logic [4:0] a);
    logic [5:0] s;
    s = {1'b0, a};
    return (s >= ALPHA_LEN) ? 5'(s - ALPHA_LEN) : a;
  endfunction

  // (a + 1) mod 26 for any 5-bit a
  function automatic logic [4:0] mod26_inc(input logic [4:0] a);
    logic [5:0] s;
    s = {1'b0, a} + 6'd1;
    return (s >= ALPHA_LEN) ? 5'(s - ALPHA_LEN) : s[4:0];
  endfunction

  // both operands below 26
  function automatic logic [4:0] mod26_add(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= ALPHA_LEN) ? 5'(s - ALPHA_LEN) : s[4:0];
  endfunction

  function automatic logic [4:0] mod26_sub(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} + ALPHA_LEN - {1'b0, b};
    return (a >= b) ? 5'(a - b) : s[4:0];
  endfunction

endpackage

FILE: src/trc_front.sv
// Front end: case folding, letter detection, rotor stepping and start registers.
module trc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_en,
  input  logic [1:0]         cfg_index,
  input  logic [4:0]         cfg_data,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  input  logic               q_full,
  output logic               push,
  output trc_pkg::trc_item_t item
);
  import trc_pkg::*;

  logic [4:0] start_r, start_m, start_l;
  logic [4:0] start_r_next, start_m_next, start_l_next;
  logic [4:0] pos_r, pos_m, pos_l;
  logic [4:0] pos_r_next, pos_m_next, pos_l_next;
  logic       load;
  logic [7:0] folded;
  logic       is_letter;

  always_comb begin
    start_r_next = start_r;
    start_m_next = start_m;
    start_l_next = start_l;
    load         = 1'b0;
    if (cfg_en) begin
      unique case (cfg_index)
        CFG_START_RIGHT: begin
          start_r_next = cfg_data;
          load         = 1'b1;
        end
        CFG_START_MIDDLE: begin
          start_m_next = cfg_data;
          load         = 1'b1;
        end
        CFG_START_LEFT: begin
          start_l_next = cfg_data;
          load         = 1'b1;
        end
        default: load = 1'b0;
      endcase
    end
  end

  always_comb begin
    folded     = (in_byte >= CHAR_LO_A && in_byte <= CHAR_LO_Z) ? in_byte - CASE_OFFSET
                                                                : in_byte;
    is_letter  = (folded >= CHAR_UP_A) && (folded <= CHAR_UP_Z);
    push       = in_valid && !q_full;
    pos_r_next = mod26_inc(pos_r);
    pos_m_next = (pos_r_next == MIDDLE_TURN) ? mod26_inc(pos_m) : pos_m;
    pos_l_next = (pos_m_next == LEFT_TURN) ? mod26_inc(pos_l) : pos_l;
    item.is_letter = is_letter;
    item.data      = is_letter ? (folded - CHAR_UP_A) : in_byte;
    item.pos_r     = pos_r_next;
    item.pos_m     = mod26_reduce(pos_m_next);
    item.pos_l     = mod26_reduce(pos_l_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_r <= '0;
      start_m <= '0;
      start_l <= '0;
      pos_r   <= '0;
      pos_m   <= '0;
      pos_l   <= '0;
    end else begin
      start_r <= start_r_next;
      start_m <= start_m_next;
      start_l <= start_l_next;
      if (load) begin
        pos_r <= start_r_next;
        pos_m <= start_m_next;
        pos_l <= start_l_next;
      end else if (push && is_letter) begin
        pos_r <= pos_r_next;
        pos_m <= pos_m_next;
        pos_l <= pos_l_next;
      end
    end
  end

endmodule

FILE: src/trc_fifo.sv
// Short request queue between the front end and the cipher pipeline.
module trc_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  trc_pkg::trc_item_t wr_item,
  output logic               full,
  input  logic               rd_en,
  output logic               not_empty,
  output trc_pkg::trc_item_t rd_item
);
  import trc_pkg::*;

  trc_item_t            slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_AW:0]     count;

  assign full      = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign rd_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/trc_back.sv
// Cipher pipeline: forward wirings, reflector, inverse wirings, output register.
module trc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  trc_pkg::trc_item_t q_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte
);
  import trc_pkg::*;

  trc_item_t  s1, s2;
  trc_item_t  s1_next, s2_next;
  logic       s1_valid, s2_valid;
  logic       s1_ready, s2_ready, out_ready;
  logic [4:0] r_back;
  logic [7:0] out_byte_next;

  always_comb begin
    out_ready = !out_valid || !out_stall;
    s2_ready  = !s2_valid || out_ready;
    s1_ready  = !s1_valid || s2_ready;
    pop       = q_not_empty && s1_ready;

    // right and middle rotors forward
    s1_next = q_item;
    if (q_item.is_letter) begin
      s1_next.data = {3'b000,
        WIRE_M[mod26_add(WIRE_R[mod26_add(q_item.data[4:0], q_item.pos_r)], q_item.pos_m)]};
    end

    // left rotor, reflector, left rotor back
    s2_next = s1;
    if (s1.is_letter) begin
      s2_next.data = {3'b000,
        mod26_sub(INV_L[REFL[WIRE_L[mod26_add(s1.data[4:0], s1.pos_l)]]], s1.pos_l)};
    end

    // middle and right rotors back
    r_back        = mod26_sub(INV_R[mod26_sub(INV_M[s2.data[4:0]], s2.pos_m)], s2.pos_r);
    out_byte_next = s2.is_letter ? ({3'b000, r_back} + CHAR_UP_A) : s2.data;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1 <= s1_next;
    end
    if (s1_valid && s2_ready) begin
      s2 <= s2_next;
    end
    if (s2_valid && out_ready) begin
      out_byte <= out_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= pop;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (out_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

endmodule

FILE: src/three_rotor_cipher.sv
// Top level of the three-rotor byte stream cipher.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------
//   in      | request in| in_valid / in_stall | in_byte[7:0]
//   out     | result out| out_valid/out_stall | out_byte[7:0]
//   cfg     | write     | cfg_en              | cfg_index[1:0], cfg_data[4:0]
//
// One request per cycle sustained while out_stall is low, through queue, s1, s2 and output.
// Rotor stepping in the front end is the only loop-carried state; positions are registered.
// Reset clears start registers and rotor positions to 0 and empties queue and pipeline.
// out_stall holds the output register and backs up a 2-stage pipeline and a 4-entry queue;
// in_stall rises only when that queue is full.
module three_rotor_cipher (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_en,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte
);
  import trc_pkg::*;

  trc_item_t push_item, q_item;
  logic      push, pop, q_full, q_not_empty;

  assign in_stall = q_full;

  trc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .q_full    (q_full),
    .push      (push),
    .item      (push_item)
  );

  trc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (push),
    .wr_item   (push_item),
    .full      (q_full),
    .rd_en     (pop),
    .not_empty (q_not_empty),
    .rd_item   (q_item)
  );

  trc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_item      (q_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte)
  );

endmodule

FILE: src/trc_checker.sv
// Port-level checks for the rotor cipher, bound to the top level.
module trc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("stalled result changed");

  a_no_lower: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_byte >= 8'h61 && out_byte <= 8'h7a))
    else $error("lower-case letter on output");

  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind three_rotor_cipher trc_checker u_trc_checker (.*);
